### rtl/core/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, codes and helpers of the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

   // map word geometry
   localparam int WORD_BITS = 32;
   localparam int WORD_LOG2 = 5;

   // operation codes
   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_INIT  = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_FREE   = 2'd1;
   localparam logic [1:0] ST_RANGE     = 2'd2;
   localparam logic [1:0] ST_DBL_FREE  = 2'd3;

   // register indexes
   localparam logic REG_TOTAL_MB = 1'b0;
   localparam logic REG_RESERVED = 1'b1;

   typedef struct packed {
      logic [1:0]  op;
      logic [27:0] page_addr;
      logic [15:0] ref_cnt;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] page_index;
      logic [27:0] page_base;
      logic [15:0] new_ref_cnt;
      logic        freed;
      logic [16:0] free_pages;
      logic [8:0]  used_mb;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ALLOC_CHK,
      S_FREE_CHK,
      S_INIT,
      S_REPLY
   } state_type;

   // position of the lowest clear bit, binary search in five steps
   function automatic logic [WORD_LOG2-1:0] lowest_zero(logic [WORD_BITS-1:0] w);
      logic [WORD_BITS-1:0] v;
      logic [WORD_LOG2-1:0] pos;
      v   = ~w;
      pos = '0;
      if (v[15:0] == 16'd0) begin
         pos[4] = 1'b1;
         v      = v >> 16;
      end
      if (v[7:0] == 8'd0) begin
         pos[3] = 1'b1;
         v      = v >> 8;
      end
      if (v[3:0] == 4'd0) begin
         pos[2] = 1'b1;
         v      = v >> 4;
      end
      if (v[1:0] == 2'd0) begin
         pos[1] = 1'b1;
         v      = v >> 2;
      end
      if (v[0] == 1'b0) begin
         pos[0] = 1'b1;
      end
      return pos;
   endfunction

endpackage

### rtl/core/bpa_map_ram.sv
// ----------------------------------------------------------------------------
// bpa_map_ram
// Used-map storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bpa_map_ram #(
   parameter int DEPTH  = 2048,
   parameter int ADDR_W = 11
) (
   input  logic                           clock,
   input  logic                           rd_en,
   input  logic [ADDR_W-1:0]              rd_addr,
   output logic [bpa_pkg::WORD_BITS-1:0]  rd_data,
   input  logic                           wr_en,
   input  logic [ADDR_W-1:0]              wr_addr,
   input  logic [bpa_pkg::WORD_BITS-1:0]  wr_data
);
   import bpa_pkg::*;

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/bitmap_page_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator_core
// First-fit page frame allocator over a one-bit-per-page used map.
// ----------------------------------------------------------------------------
// Usage: one request beat (alloc, free or init) gives one response beat.
// Both channels move a beat when valid is high and stall is low. The csr
// port writes total_mb (index 0) and the reserve page count (index 1); the
// user must write them only while idle, the block itself does not enforce it.
// The map sits in a RAM of 32-bit words with registered reads; alloc and
// free items that reach the map are read-modify-write on that RAM, one item
// at a time. Alloc scans from a low-water word pointer (all words below it
// are full), reading on past each full word. A free that checks the map
// reads the word, then clears the page's bit or reports a double free.
// Answers that need no map access (shared free, range error, no free page,
// zero-limit init, unused op) go straight to the reply step. Init sweeps
// ceil(limit/32) words, one per cycle (2048 at 256 MB, 4 KB pages), then
// replies. A new request is taken once the block is back in idle, which it
// enters as the response register loads, so items never overlap.
// The response register holds its beat while rsp_stall is high; the next
// request is still accepted and works until its result waits for space.
// Reset (synchronous) zeroes page limit and counts and loads total_mb 256 and
// reserve 4096; the map needs no clearing as no read precedes an init rewrite.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_core #(
   parameter int NUM_PAGES       = 65536,
   parameter int PAGE_BYTES_LOG2 = 12
) (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_stall,
   input  bpa_pkg::req_type req_data,
   // response channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bpa_pkg::rsp_type rsp_data,
   // register write port
   input  logic             csr_wr_en,
   input  logic             csr_index,
   input  logic [16:0]      csr_wr_data
);
   import bpa_pkg::*;

   localparam int WORDS    = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int WA_W     = $clog2(WORDS);
   localparam int PTR_W    = WA_W + 1;             // can hold WORDS itself
   localparam int CNT_W    = $clog2(NUM_PAGES + 1);
   localparam int MB_SHIFT = 20 - PAGE_BYTES_LOG2;

   // ---------------------------------------------------------------- state
   state_type           state_ff, state_in;
   req_type             cmd_ff, cmd_in;
   logic [8:0]          total_mb_ff;
   logic [16:0]         reserved_ff;
   logic [CNT_W-1:0]    limit_ff, limit_in;
   logic [CNT_W-1:0]    free_cnt_ff, free_cnt_in;
   logic [CNT_W-1:0]    used_cnt_ff, used_cnt_in;
   logic [CNT_W-1:0]    res_ff, res_in;          // reserved pages of this init
   logic [PTR_W-1:0]    lo_ptr_ff, lo_ptr_in;    // lowest word that may be free
   logic [PTR_W-1:0]    init_ptr_ff, init_ptr_in;
   logic [PTR_W-1:0]    init_last_ff, init_last_in;
   rsp_type             rsl_ff, rsl_in;          // result before counters
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // ------------------------------------------------------------------ RAM
   logic                 ram_rd_en;
   logic [WA_W-1:0]      ram_rd_addr;
   logic [WORD_BITS-1:0] ram_rd_data;
   logic                 ram_wr_en;
   logic [WA_W-1:0]      ram_wr_addr;
   logic [WORD_BITS-1:0] ram_wr_data;

   bpa_map_ram #(
      .DEPTH  (WORDS),
      .ADDR_W (WA_W)
   ) u_map (
      .clock   (clock),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data)
   );

   // ------------------------------------------------------------- helpers
   logic [31:0]          idx_req;      // page index of a free request
   logic [31:0]          idx_cmd;
   logic [31:0]          lim_raw;
   logic [CNT_W-1:0]     lim_new;
   logic [CNT_W-1:0]     res_new;
   logic [31:0]          lim_word;
   logic [WORD_BITS-1:0] alloc_mask;   // bits at or beyond the page limit
   logic [WORD_BITS-1:0] alloc_word;
   logic [WORD_LOG2-1:0] alloc_bit;
   logic [WORD_BITS-1:0] alloc_set;
   logic [WA_W+WORD_LOG2-1:0] alloc_page;
   logic [WORD_LOG2-1:0] free_bit;
   logic [PTR_W-1:0]     free_word;
   logic [31:0]          res_word;
   logic [WORD_BITS-1:0] init_word;

   assign idx_req  = 32'(req_data.page_addr) >> PAGE_BYTES_LOG2;
   assign idx_cmd  = 32'(cmd_ff.page_addr) >> PAGE_BYTES_LOG2;

   // page limit from installed memory, capped at the map size
   assign lim_raw  = 32'(total_mb_ff) << MB_SHIFT;
   assign lim_new  = (lim_raw > 32'(NUM_PAGES)) ? CNT_W'(NUM_PAGES) : lim_raw[CNT_W-1:0];
   assign res_new  = (32'(reserved_ff) < 32'(lim_new)) ? CNT_W'(reserved_ff) : lim_new;

   assign lim_word = 32'(limit_ff >> WORD_LOG2);

   always_comb begin
      if (32'(lo_ptr_ff) < lim_word) begin
         alloc_mask = '0;
      end else if (32'(lo_ptr_ff) == lim_word) begin
         alloc_mask = ~((WORD_BITS'(1) << limit_ff[WORD_LOG2-1:0]) - WORD_BITS'(1));
      end else begin
         alloc_mask = '1;
      end
   end

   assign alloc_word = ram_rd_data | alloc_mask;
   assign alloc_bit  = lowest_zero(alloc_word);
   assign alloc_set  = WORD_BITS'(1) << alloc_bit;
   assign alloc_page = {lo_ptr_ff[WA_W-1:0], alloc_bit};

   assign free_bit   = idx_cmd[WORD_LOG2-1:0];
   assign free_word  = {1'b0, idx_cmd[WA_W+WORD_LOG2-1:WORD_LOG2]};

   // init sweep: full words below the reserved boundary, partial at it
   assign res_word   = 32'(res_ff >> WORD_LOG2);
   always_comb begin
      if (32'(init_ptr_ff) < res_word) begin
         init_word = '1;
      end else if (32'(init_ptr_ff) == res_word) begin
         init_word = (WORD_BITS'(1) << res_ff[WORD_LOG2-1:0]) - WORD_BITS'(1);
      end else begin
         init_word = '0;
      end
   end

   // ------------------------------------------------------ next state
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      limit_in     = limit_ff;
      free_cnt_in  = free_cnt_ff;
      used_cnt_in  = used_cnt_ff;
      res_in       = res_ff;
      lo_ptr_in    = lo_ptr_ff;
      init_ptr_in  = init_ptr_ff;
      init_last_in = init_last_ff;
      rsl_in       = rsl_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = lo_ptr_ff[WA_W-1:0];
      ram_wr_en    = 1'b0;
      ram_wr_addr  = lo_ptr_ff[WA_W-1:0];
      ram_wr_data  = ram_rd_data;
      req_stall    = (state_ff != S_IDLE);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_data;
               rsl_in   = '0;
               state_in = S_REPLY;
               case (req_data.op)
                  OP_ALLOC: begin
                     if (free_cnt_ff == '0) begin
                        rsl_in.status = ST_NO_FREE;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = lo_ptr_ff[WA_W-1:0];
                        state_in    = S_ALLOC_CHK;
                     end
                  end
                  OP_FREE: begin
                     if (req_data.ref_cnt > 16'd1) begin
                        rsl_in.new_ref_cnt = req_data.ref_cnt - 16'd1;
                     end else if (idx_req >= 32'(limit_ff)) begin
                        rsl_in.status = ST_RANGE;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = idx_req[WA_W+WORD_LOG2-1:WORD_LOG2];
                        state_in    = S_FREE_CHK;
                     end
                  end
                  OP_INIT: begin
                     limit_in     = lim_new;
                     res_in       = res_new;
                     init_ptr_in  = '0;
                     init_last_in = PTR_W'(((32'(lim_new) + 32'(WORD_BITS - 1))
                                           >> WORD_LOG2) - 32'd1);
                     if (lim_new == '0) begin
                        free_cnt_in = '0;
                        used_cnt_in = '0;
                        lo_ptr_in   = '0;
                     end else begin
                        state_in = S_INIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_ALLOC_CHK: begin
            if (&alloc_word) begin
               // word full: move the low-water pointer and read on
               lo_ptr_in   = lo_ptr_ff + 1'b1;
               ram_rd_en   = 1'b1;
               ram_rd_addr = lo_ptr_in[WA_W-1:0];
            end else begin
               ram_wr_en            = 1'b1;
               ram_wr_addr          = lo_ptr_ff[WA_W-1:0];
               ram_wr_data          = ram_rd_data | alloc_set;
               free_cnt_in          = free_cnt_ff - 1'b1;
               used_cnt_in          = used_cnt_ff + 1'b1;
               rsl_in.status        = ST_OK;
               rsl_in.page_index    = 16'(alloc_page);
               rsl_in.page_base     = 28'(48'(alloc_page) << PAGE_BYTES_LOG2);
               rsl_in.new_ref_cnt   = 16'd1;
               if (&(alloc_word | alloc_set)) begin
                  lo_ptr_in = lo_ptr_ff + 1'b1;
               end
               state_in = S_REPLY;
            end
         end

         S_FREE_CHK: begin
            if (!ram_rd_data[free_bit]) begin
               rsl_in.status = ST_DBL_FREE;
            end else begin
               ram_wr_en    = 1'b1;
               ram_wr_addr  = free_word[WA_W-1:0];
               ram_wr_data  = ram_rd_data & ~(WORD_BITS'(1) << free_bit);
               free_cnt_in  = free_cnt_ff + 1'b1;
               if (used_cnt_ff != '0) begin
                  used_cnt_in = used_cnt_ff - 1'b1;
               end
               rsl_in.freed = 1'b1;
               if (free_word < lo_ptr_ff) begin
                  lo_ptr_in = free_word;
               end
            end
            state_in = S_REPLY;
         end

         S_INIT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = init_ptr_ff[WA_W-1:0];
            ram_wr_data = init_word;
            init_ptr_in = init_ptr_ff + 1'b1;
            if (init_ptr_ff == init_last_ff) begin
               used_cnt_in = res_ff;
               free_cnt_in = limit_ff - res_ff;
               lo_ptr_in   = PTR_W'(res_ff >> WORD_LOG2);
               state_in    = S_REPLY;
            end
         end

         S_REPLY: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in            = rsl_ff;
               rsp_in.free_pages = 17'(free_cnt_ff);
               rsp_in.used_mb    = 9'(used_cnt_ff >> MB_SHIFT);
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------ registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         limit_ff     <= '0;
         free_cnt_ff  <= '0;
         used_cnt_ff  <= '0;
         lo_ptr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         total_mb_ff  <= 9'd256;
         reserved_ff  <= 17'd4096;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         free_cnt_ff  <= free_cnt_in;
         used_cnt_ff  <= used_cnt_in;
         lo_ptr_ff    <= lo_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               REG_TOTAL_MB: total_mb_ff <= csr_wr_data[8:0];
               REG_RESERVED: reserved_ff <= csr_wr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      res_ff       <= res_in;
      init_ptr_ff  <= init_ptr_in;
      init_last_ff <= init_last_in;
      rsl_ff       <= rsl_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ----------------------------------------------------------- assertions
   // every page below the limit is counted once, free or used
   a_count_sum: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |->
         ((CNT_W+1)'(free_cnt_ff) + (CNT_W+1)'(used_cnt_ff)) == (CNT_W+1)'(limit_ff))
      else $error("free and used page counts do not add up to the limit");

   // one item at a time: an accepted beat leaves idle
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while an item is in work");

   // map writes only come from the modify steps and the init sweep
   a_wr_state: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == S_ALLOC_CHK || state_ff == S_FREE_CHK ||
                     state_ff == S_INIT))
      else $error("map write outside a modify state");

   // a new response only loads from the reply step
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_REPLY))
      else $error("response raised without a reply step");

endmodule
